### rtl/core/cmf3_pkg.sv
// Shared constants, types and helper functions of the 3x3 colour median filter.
package cmf3_pkg;

  // Geometry limits and register reset values
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned WIDTH_RST     = 640;
  localparam int unsigned HEIGHT_RST    = 480;
  localparam int unsigned ROW_W         = 13;

  // Pixel format: blue in the low byte, then green, then red
  localparam int unsigned CH_W  = 8;
  localparam int unsigned PIX_W = 3 * CH_W;
  localparam int unsigned SUM_W = 10;

  // Window and ranking
  localparam int unsigned WIN_N  = 9;
  localparam int unsigned RANK_W = 4;

  // Configuration channel
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_WIDTH_W  = 11;
  localparam int unsigned CFG_HEIGHT_W = 13;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = 3;
  localparam int unsigned FIFO_CNT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef logic [PIX_W-1:0] pix_t;

  // Control carried alongside an item into the line-memory stage
  typedef struct packed {
    logic             shift;
    logic             wr;
    logic             rowend;
    logic             has_res;
    logic [WIN_N-1:0] mask;
    logic             eol;
    logic             eof;
    pix_t             pix;
  } s1_ctrl_t;

  typedef struct packed {
    logic eof;
    logic eol;
    pix_t pix;
  } result_t;

  function automatic logic [SUM_W-1:0] chan_sum(input pix_t p);
    return SUM_W'(p[CH_W-1:0]) + SUM_W'(p[2*CH_W-1:CH_W]) + SUM_W'(p[3*CH_W-1:2*CH_W]);
  endfunction

  function automatic logic [RANK_W-1:0] popcount9(input logic [WIN_N-1:0] v);
    logic [RANK_W-1:0] n;
    n = '0;
    for (int i = 0; i < WIN_N; i++) begin
      n = n + RANK_W'(v[i]);
    end
    return n;
  endfunction

endpackage

### rtl/core/color_median_filter_3x3_unit.sv
// Streaming 3x3 colour median filter with line memory, ranking pipeline and result queue.
//
// Raster pixels enter on the slave stream (tdata: blue, green, red from bit 0;
// tuser: 1 marks a flush tick) and median pixels leave on the master stream,
// with tlast marking the last pixel of a row and tuser the last pixel of the
// frame. Pixels are ranked by blue+green+red; equal sums keep scan order, top
// row first, then left to right. At the borders only in-image neighbours
// count (4, 6 or 9 if width and height are at least 2) and the pixel of rank
// count/2 is chosen. The result for raster position p leaves after the transfer
// that brings item p+width+1, so image_width+1 flush ticks (or pixels, whose
// data is then dropped) drain the frame; a flush tick before the frame's last
// pixel is taken and has no effect. The block takes one item per clock while its
// result buffer has room: each transfer does one read-modify-write of the
// single 48-bit line memory (two stored rows per column, registered read, last
// write forwarded for the one-pixel-wide case) and the ranking runs as a
// four-stage pipeline behind it. Results queue in an eight-entry buffer; tready
// depends only on its fill level plus the results still in the pipeline, so a
// stalled output side stops the input only once that buffer is spoken for. After
// its window completes, a median passes stages 1 to 4 into that buffer. The line memory
// needs no clearing pass: entries never written are read only into window
// places outside the image. Any configuration write restarts the frame.
module color_median_filter_3x3_unit #(
  parameter int unsigned MAX_WIDTH = cmf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Slave stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cmf3_pkg::PIX_W-1:0]        s_axis_tdata,  // in_blue, in_green, in_red
  input  logic [0:0]                        s_axis_tuser,  // action
  // Master stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cmf3_pkg::PIX_W-1:0]        m_axis_tdata,  // out_blue, out_green, out_red
  output logic                              m_axis_tlast,  // end_of_line
  output logic [0:0]                        m_axis_tuser,  // end_of_frame
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cmf3_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cmf3_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WCNT_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WCMP_W    = (WCNT_W > cmf3_pkg::CFG_WIDTH_W) ? WCNT_W
                                                                       : cmf3_pkg::CFG_WIDTH_W;
  localparam int unsigned WIDTH_RST = (cmf3_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                                        : cmf3_pkg::WIDTH_RST;
  localparam int unsigned OCC_W     = cmf3_pkg::FIFO_CNT_W + 1;
  localparam int unsigned PIX_W     = cmf3_pkg::PIX_W;
  localparam int unsigned WIN_N     = cmf3_pkg::WIN_N;
  localparam int unsigned ROW_W     = cmf3_pkg::ROW_W;
  localparam int unsigned SUM_W     = cmf3_pkg::SUM_W;
  localparam int unsigned RANK_W    = cmf3_pkg::RANK_W;

  // ---------------------------------------------------------------------------
  // Configuration registers, stored already clamped to the legal range
  // ---------------------------------------------------------------------------
  logic                    cfg_we;
  logic [WCNT_W-1:0]       width_q;
  logic [ROW_W-1:0]        height_q;
  logic [WCMP_W-1:0]       cfg_w_ext;
  logic [WCNT_W-1:0]       width_clamped;
  logic [ROW_W-1:0]        height_clamped;
  logic [cmf3_pkg::CFG_HEIGHT_W-1:0] cfg_h_raw;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_w_ext   = WCMP_W'(cfg_data_i[cmf3_pkg::CFG_WIDTH_W-1:0]);
  assign cfg_h_raw   = cfg_data_i[cmf3_pkg::CFG_HEIGHT_W-1:0];

  always_comb begin
    if (cfg_w_ext == '0) begin
      width_clamped = WCNT_W'(1);
    end else if (cfg_w_ext > WCMP_W'(MAX_WIDTH)) begin
      width_clamped = WCNT_W'(MAX_WIDTH);
    end else begin
      width_clamped = WCNT_W'(cfg_w_ext);
    end
    if (cfg_h_raw == '0) begin
      height_clamped = ROW_W'(1);
    end else if (cfg_h_raw > ROW_W'(cmf3_pkg::MAX_HEIGHT)) begin
      height_clamped = ROW_W'(cmf3_pkg::MAX_HEIGHT);
    end else begin
      height_clamped = ROW_W'(cfg_h_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WCNT_W'(WIDTH_RST);
      height_q <= ROW_W'(cmf3_pkg::HEIGHT_RST);
    end else if (cfg_we) begin
      case (cmf3_pkg::cfg_reg_e'(cfg_index_i))
        cmf3_pkg::CFG_IMAGE_WIDTH:  width_q  <= width_clamped;
        cmf3_pkg::CFG_IMAGE_HEIGHT: height_q <= height_clamped;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking and item classification at the input transfer
  // ---------------------------------------------------------------------------
  logic                 in_xfer;
  logic                 take;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic                 row_lt_h, row_le_h, past_end, col_zero;
  logic                 normal_res;
  logic [WCNT_W-1:0]    col_inc;
  logic                 wide;
  logic                 r0v, r2v, c0v;
  cmf3_pkg::s1_ctrl_t   s0_ctrl;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign row_lt_h = row_q < height_q;
  assign row_le_h = row_q <= height_q;
  assign past_end = row_q > height_q;
  assign col_zero = col_q == '0;
  assign wide     = width_q > WCNT_W'(1);
  // A flush tick inside the frame is taken but leaves everything as it was
  assign take     = in_xfer &&
                    !(row_lt_h && (cmf3_pkg::action_e'(s_axis_tuser[0]) == cmf3_pkg::ACT_FLUSH));
  assign col_inc  = WCNT_W'(col_q) + WCNT_W'(1);
  assign normal_res = !col_zero && (row_q >= ROW_W'(1));

  always_comb begin
    s0_ctrl.shift   = row_le_h;
    s0_ctrl.wr      = row_lt_h;
    s0_ctrl.rowend  = col_zero && (row_q >= ROW_W'(2));
    s0_ctrl.has_res = s0_ctrl.rowend || normal_res;
    s0_ctrl.eol     = s0_ctrl.rowend;
    s0_ctrl.eof     = s0_ctrl.rowend && past_end;
    s0_ctrl.pix     = row_lt_h ? s_axis_tdata : '0;
    s0_ctrl.mask    = '0;
    if (s0_ctrl.rowend) begin
      // Pre-shift window: column 2 is the last image column, column 1 the one before
      r0v = row_q >= ROW_W'(3);
      r2v = row_le_h;
      s0_ctrl.mask[0] = 1'b0;
      s0_ctrl.mask[1] = r0v && wide;
      s0_ctrl.mask[2] = r0v;
      s0_ctrl.mask[3] = 1'b0;
      s0_ctrl.mask[4] = wide;
      s0_ctrl.mask[5] = 1'b1;
      s0_ctrl.mask[6] = 1'b0;
      s0_ctrl.mask[7] = r2v && wide;
      s0_ctrl.mask[8] = r2v;
    end else begin
      // Post-shift window centred on the previous column of the previous row
      r0v = row_q >= ROW_W'(2);
      r2v = row_lt_h;
      c0v = col_q >= COL_W'(2);
      s0_ctrl.mask[0] = r0v && c0v;
      s0_ctrl.mask[1] = r0v;
      s0_ctrl.mask[2] = r0v;
      s0_ctrl.mask[3] = c0v;
      s0_ctrl.mask[4] = 1'b1;
      s0_ctrl.mask[5] = 1'b1;
      s0_ctrl.mask[6] = r2v && c0v;
      s0_ctrl.mask[7] = r2v;
      s0_ctrl.mask[8] = r2v;
    end
    if (!s0_ctrl.rowend) begin
      c0v = col_q >= COL_W'(2);
    end else begin
      c0v = 1'b0;
    end

    // Advance the raster position; the tick after the drain row restarts the frame
    if (past_end) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= width_q) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: {second upper row, upper row} per column
  // ---------------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd_q;
  logic [2*PIX_W-1:0] line_cur;
  logic [2*PIX_W-1:0] line_wr;
  logic               line_we;

  logic               s1_vld_q;
  cmf3_pkg::s1_ctrl_t s1_q;
  logic [COL_W-1:0]   s1_addr_q;

  logic               fwd_vld_q;
  logic [COL_W-1:0]   fwd_addr_q;
  logic [2*PIX_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      line_rd_q <= line_mem[col_q];
    end
    if (line_we) begin
      line_mem[s1_addr_q] <= line_wr;
    end
  end

  // Forward the last write: an item at the same column in the next cycle read stale data
  assign line_cur = (fwd_vld_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : line_rd_q;
  assign line_wr  = {line_cur[PIX_W-1:0], s1_q.pix};
  assign line_we  = s1_vld_q && s1_q.wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= take;
      if (line_we) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q      <= s0_ctrl;
      s1_addr_q <= col_q;
    end
    if (line_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= line_wr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: window shift and choice of pre- or post-shift window
  // ---------------------------------------------------------------------------
  cmf3_pkg::pix_t win_q [WIN_N];
  cmf3_pkg::pix_t win_d [WIN_N];

  always_comb begin
    win_d = win_q;
    if (s1_vld_q && s1_q.shift) begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = line_cur[2*PIX_W-1:PIX_W];
      win_d[3] = win_q[4];
      win_d[4] = win_q[5];
      win_d[5] = line_cur[PIX_W-1:0];
      win_d[6] = win_q[7];
      win_d[7] = win_q[8];
      win_d[8] = s1_q.pix;
    end
  end

  logic             s2_vld_q;
  cmf3_pkg::pix_t   s2_win_q [WIN_N];
  logic [WIN_N-1:0] s2_mask_q;
  logic             s2_eol_q, s2_eof_q;

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (s1_vld_q) begin
      // Row-end results use the window as it stood before this item's shift
      s2_win_q  <= s1_q.rowend ? win_q : win_d;
      s2_mask_q <= s1_q.mask;
      s2_eol_q  <= s1_q.eol;
      s2_eof_q  <= s1_q.eof;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: channel sums
  // ---------------------------------------------------------------------------
  logic             s3_vld_q;
  cmf3_pkg::pix_t   s3_win_q [WIN_N];
  logic [SUM_W-1:0] s3_sum_q [WIN_N];
  logic [WIN_N-1:0] s3_mask_q;
  logic             s3_eol_q, s3_eof_q;

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      for (int i = 0; i < WIN_N; i++) begin
        s3_sum_q[i] <= cmf3_pkg::chan_sum(s2_win_q[i]);
      end
      s3_win_q  <= s2_win_q;
      s3_mask_q <= s2_mask_q;
      s3_eol_q  <= s2_eol_q;
      s3_eof_q  <= s2_eof_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pairwise order, ties broken by scan position
  // ---------------------------------------------------------------------------
  logic [WIN_N-1:0] lt [WIN_N];

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      for (int j = 0; j < WIN_N; j++) begin
        lt[i][j] = s3_mask_q[j] &&
                   ((s3_sum_q[j] < s3_sum_q[i]) || ((s3_sum_q[j] == s3_sum_q[i]) && (j < i)));
      end
    end
  end

  logic             s4_vld_q;
  cmf3_pkg::pix_t   s4_win_q [WIN_N];
  logic [WIN_N-1:0] s4_lt_q  [WIN_N];
  logic [WIN_N-1:0] s4_mask_q;
  logic             s4_eol_q, s4_eof_q;

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      s4_lt_q   <= lt;
      s4_win_q  <= s3_win_q;
      s4_mask_q <= s3_mask_q;
      s4_eol_q  <= s3_eol_q;
      s4_eof_q  <= s3_eof_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: rank count and selection of the middle candidate
  // ---------------------------------------------------------------------------
  logic [RANK_W-1:0] cand_cnt, half;
  logic [RANK_W-1:0] rank [WIN_N];
  logic [WIN_N-1:0]  sel;
  cmf3_pkg::pix_t    med_pix;
  cmf3_pkg::result_t res;

  always_comb begin
    cand_cnt = cmf3_pkg::popcount9(s4_mask_q);
    half     = cand_cnt >> 1;
    med_pix  = '0;
    for (int i = 0; i < WIN_N; i++) begin
      rank[i] = cmf3_pkg::popcount9(s4_lt_q[i]);
      sel[i]  = s4_mask_q[i] && (rank[i] == half);
      med_pix = med_pix | (sel[i] ? s4_win_q[i] : '0);
    end
    res.pix = med_pix;
    res.eol = s4_eol_q;
    res.eof = s4_eof_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q && s1_q.has_res;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue and input budget
  // ---------------------------------------------------------------------------
  cmf3_pkg::result_t                  fifo_q [cmf3_pkg::FIFO_DEPTH];
  logic [cmf3_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [cmf3_pkg::FIFO_CNT_W-1:0]    fifo_cnt_q;
  logic                               push, pop;
  logic [OCC_W-1:0]                   occupancy;
  cmf3_pkg::result_t                  head;

  assign push = s4_vld_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  // Results already promised: queued plus still in the pipeline
  assign occupancy = OCC_W'(fifo_cnt_q) + OCC_W'(s1_vld_q && s1_q.has_res) +
                     OCC_W'(s2_vld_q) + OCC_W'(s3_vld_q) + OCC_W'(s4_vld_q);
  assign s_axis_tready = occupancy < OCC_W'(cmf3_pkg::FIFO_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + cmf3_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + cmf3_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + cmf3_pkg::FIFO_CNT_W'(1);
      end else if (!push && pop) begin
        fifo_cnt_q <= fifo_cnt_q - cmf3_pkg::FIFO_CNT_W'(1);
      end
    end
  end

  assign head            = fifo_q[rd_ptr_q];
  assign m_axis_tvalid   = fifo_cnt_q != '0;
  assign m_axis_tdata    = head.pix;
  assign m_axis_tlast    = head.eol;
  assign m_axis_tuser[0] = head.eof;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= OCC_W'(cmf3_pkg::FIFO_DEPTH))
    else $error("result budget exceeded");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q < cmf3_pkg::FIFO_CNT_W'(cmf3_pkg::FIFO_DEPTH)) || pop)
    else $error("result queue overflow");

  a_one_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q |-> $onehot(sel))
    else $error("median selection is not unique");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= height_q + ROW_W'(1))
    else $error("row position beyond drain row");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WCNT_W'(col_q) < width_q)
    else $error("column position beyond image width");

endmodule
